### sv/online_viterbi_state_estimator_macros.svh
// assertion macros for the viterbi estimator checker
`ifndef ONLINE_VITERBI_STATE_ESTIMATOR_MACROS_SVH
`define ONLINE_VITERBI_STATE_ESTIMATOR_MACROS_SVH
// implication checked on every rising clock edge, reset excluded
`define OVSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define OVSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/ovse_pkg.sv
// ----------------------------------------------------------------------------
// ovse_pkg
// types and constants shared by the viterbi estimator files
// ----------------------------------------------------------------------------
package ovse_pkg;

  localparam int unsigned DEF_MAX_STATES  = 16;
  localparam int unsigned DEF_MAX_SYMBOLS = 16;
  localparam int unsigned DEF_SCORE_WIDTH = 24;

  localparam logic [2:0] ACT_OBSERVE = 3'd0;
  localparam logic [2:0] ACT_LOAD_PI = 3'd1;
  localparam logic [2:0] ACT_LOAD_TR = 3'd2;
  localparam logic [2:0] ACT_LOAD_EM = 3'd3;
  localparam logic [2:0] ACT_RESTART = 3'd4;

  localparam logic CFG_STATES  = 1'b0;
  localparam logic CFG_SYMBOLS = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         from_state;
    logic [3:0]         to_index;
    logic signed [15:0] log_value;
    logic [3:0]         symbol;
  } in_word_t;

  typedef struct packed {
    logic [3:0] best_state;
    logic [3:0] echo_symbol;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_EMIS,
    ST_COPY,
    ST_ARG,
    ST_DONE
  } state_t;

endpackage

### sv/ovse_ram.sv
// ----------------------------------------------------------------------------
// ovse_ram
// generic single-port-write, registered-read memory
// ----------------------------------------------------------------------------
module ovse_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/online_viterbi_state_estimator.sv
// ----------------------------------------------------------------------------
// online_viterbi_state_estimator
// hmm online viterbi step with one shared add-compare unit
// ----------------------------------------------------------------------------
// usage:
//   in_ channel: word taken when start is high and busy is low. loads and
//   restart leave busy low. once a symbol has been seen, an observe word
//   walks every (k, j) state pair through one saturating add and compare,
//   reading pi, transition and emission from memories with a registered read
//   port; scores are held in registers.
//   steps of an observe word, n = states in use: on the first symbol a read
//   and an emission add per state; on later symbols a read and an accumulate
//   for every (k, j) pair plus one emission add per state; then a copy step,
//   an argmax step for each state from 1 to n - 1, and a result step.
//   busy drops after the result step and the next word can then be taken;
//   loads, restart and ignored words do not raise busy.
//   out_ channel: out_valid strobes one cycle with best_state and echo_symbol;
//   the receiver cannot stall, so the result is simply presented.
//   cfg_ channel: always ready; index 0 states_in_use, 1 symbols_in_use.
//   reset: scores clear to zero, no symbol seen, both counts 16; tables are
//   undefined until loaded. restart clears the scores.
// ----------------------------------------------------------------------------
module online_viterbi_state_estimator
  import ovse_pkg::*;
#(
  parameter int unsigned MAX_STATES  = DEF_MAX_STATES,
  parameter int unsigned MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int unsigned SCORE_WIDTH = DEF_SCORE_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int unsigned SB = $clog2(MAX_STATES);
  localparam int unsigned YB = $clog2(MAX_SYMBOLS);
  localparam int unsigned TD = MAX_STATES * MAX_STATES;
  localparam int unsigned ED = MAX_STATES * MAX_SYMBOLS;
  localparam logic signed [SCORE_WIDTH:0] SMAX = {2'b00, {(SCORE_WIDTH-1){1'b1}}};
  localparam logic signed [SCORE_WIDTH:0] SMIN = {2'b11, {(SCORE_WIDTH-1){1'b0}}};

  state_t state_r, state_nxt;
  logic [4:0] nst_r, nsy_r;
  logic       started_r, started_nxt;
  logic [SB-1:0] j_r, j_nxt, k_r, k_nxt, best_r, best_nxt;
  logic [3:0] sym_r;
  logic signed [SCORE_WIDTH-1:0] acc_r, acc_nxt;
  logic signed [SCORE_WIDTH-1:0] score_r [MAX_STATES];
  logic signed [SCORE_WIDTH-1:0] next_r  [MAX_STATES];
  logic first_r, first_nxt;

  // state count and symbol count after clamping
  logic [SB:0] n_st;
  logic [YB:0] n_sy;
  always_comb begin
    n_st = (nst_r == 5'd0) ? (SB+1)'(1) :
           (32'(nst_r) > MAX_STATES) ? (SB+1)'(MAX_STATES) : (SB+1)'(nst_r);
    n_sy = (nsy_r == 5'd0) ? (YB+1)'(1) :
           (32'(nsy_r) > MAX_SYMBOLS) ? (YB+1)'(MAX_SYMBOLS) : (YB+1)'(nsy_r);
  end
  logic [SB-1:0] last_st;
  assign last_st = SB'(n_st - 1'b1);

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // load decode
  logic row_ok, col_st_ok, col_sy_ok;
  assign row_ok    = 32'(in_word.from_state) < MAX_STATES;
  assign col_st_ok = 32'(in_word.to_index) < MAX_STATES;
  assign col_sy_ok = 32'(in_word.to_index) < MAX_SYMBOLS;

  logic pi_we, tr_we, em_we;
  assign pi_we = accept && in_word.action == ACT_LOAD_PI && col_st_ok;
  assign tr_we = accept && in_word.action == ACT_LOAD_TR && row_ok && col_st_ok;
  assign em_we = accept && in_word.action == ACT_LOAD_EM && row_ok && col_sy_ok;

  // table memories, read addresses from the sequencer
  logic [15:0] pi_q, tr_q, em_q;
  logic [SB-1:0] pi_ra;
  logic [$clog2(TD)-1:0] tr_ra;
  logic [$clog2(ED)-1:0] em_ra;
  logic [$clog2(TD)-1:0] tr_wa;
  logic [$clog2(ED)-1:0] em_wa;
  assign tr_wa = $clog2(TD)'(32'(in_word.from_state) * MAX_STATES + 32'(in_word.to_index));
  assign em_wa = $clog2(ED)'(32'(in_word.from_state) * MAX_SYMBOLS + 32'(in_word.to_index));

  ovse_ram #(.WIDTH(16), .DEPTH(MAX_STATES)) u_pi (
    .clk, .we(pi_we), .waddr(SB'(in_word.to_index)), .wdata(in_word.log_value),
    .raddr(pi_ra), .rdata(pi_q));
  ovse_ram #(.WIDTH(16), .DEPTH(TD)) u_tr (
    .clk, .we(tr_we), .waddr(tr_wa), .wdata(in_word.log_value),
    .raddr(tr_ra), .rdata(tr_q));
  ovse_ram #(.WIDTH(16), .DEPTH(ED)) u_em (
    .clk, .we(em_we), .waddr(em_wa), .wdata(in_word.log_value),
    .raddr(em_ra), .rdata(em_q));

  // read addresses track the pair being fetched this cycle
  assign pi_ra = j_r;
  assign tr_ra = $clog2(TD)'(32'(k_r) * MAX_STATES + 32'(j_r));
  assign em_ra = $clog2(ED)'(32'(j_r) * MAX_SYMBOLS + 32'(sym_r));

  // shared saturating adder: operand a plus operand b
  logic signed [SCORE_WIDTH-1:0] add_a, add_q;
  logic signed [15:0] add_b;
  logic signed [SCORE_WIDTH:0] add_raw;
  assign add_raw = (SCORE_WIDTH+1)'(add_a) + (SCORE_WIDTH+1)'(add_b);
  assign add_q = (add_raw > SMAX) ? SCORE_WIDTH'(SMAX) :
                 (add_raw < SMIN) ? SCORE_WIDTH'(SMIN) : SCORE_WIDTH'(add_raw);

  // k of the pair whose read data lands now
  logic [SB-1:0] kd_r;

  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    acc_nxt     = acc_r;
    best_nxt    = best_r;
    first_nxt   = first_r;
    started_nxt = started_r;
    add_a       = acc_r;
    add_b       = tr_q;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_word.action == ACT_RESTART) begin
          started_nxt = 1'b0;
        end
        if (accept && in_word.action == ACT_OBSERVE &&
            (YB+1)'(in_word.symbol) < n_sy) begin
          state_nxt = ST_RD;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RD: begin
        // read issued for (k, j); data next cycle
        first_nxt = (k_r == '0);
        state_nxt = started_r ? ST_ACC : ST_EMIS;
      end
      ST_ACC: begin
        // candidate = score[kd] + trans, keep max
        add_a = score_r[kd_r];
        add_b = tr_q;
        first_nxt = 1'b0;
        if (first_r || add_q > acc_r) begin
          acc_nxt = add_q;
        end
        if (k_r == last_st && kd_r == last_st) begin
          state_nxt = ST_EMIS;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_EMIS: begin
        add_a = started_r ? acc_r : SCORE_WIDTH'(signed'(pi_q));
        add_b = em_q;
        k_nxt = '0;
        if (j_r == last_st) begin
          state_nxt = ST_COPY;
          j_nxt     = '0;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_COPY: begin
        started_nxt = 1'b1;
        best_nxt    = '0;
        j_nxt       = SB'(1);
        state_nxt   = (last_st == '0) ? ST_DONE : ST_ARG;
      end
      ST_ARG: begin
        if (score_r[j_r] > score_r[best_r]) begin
          best_nxt = j_r;
        end
        if (j_r == last_st) begin
          state_nxt = ST_DONE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_word.best_state  = 4'(best_r);
  assign out_word.echo_symbol = sym_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
      nst_r     <= 5'd16;
      nsy_r     <= 5'd16;
      for (int i = 0; i < MAX_STATES; i++) begin
        score_r[i] <= '0;
        next_r[i]  <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STATES:  nst_r <= cfg_data;
          CFG_SYMBOLS: nsy_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_word.action == ACT_RESTART) begin
        for (int i = 0; i < MAX_STATES; i++) begin
          score_r[i] <= '0;
          next_r[i]  <= '0;
        end
      end
      if (state_r == ST_EMIS) begin
        next_r[j_r] <= add_q;
      end
      if (state_r == ST_COPY) begin
        for (int i = 0; i < MAX_STATES; i++) begin
          if (i < 32'(n_st)) score_r[i] <= next_r[i];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    kd_r    <= k_r;
    acc_r   <= acc_nxt;
    best_r  <= best_nxt;
    first_r <= first_nxt;
    if (accept) begin
      sym_r <= in_word.symbol;
    end
  end

endmodule

### sv/ovse_checker.sv
// ----------------------------------------------------------------------------
// ovse_checker
// port-level checks on the viterbi estimator
// ----------------------------------------------------------------------------
`include "online_viterbi_state_estimator_macros.svh"
module ovse_checker
  import ovse_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input in_word_t  in_word,
  input logic      cfg_ready
);
  // a load, restart or spare word taken this cycle
  logic load_acc;
  assign load_acc = start && !busy && in_word.action != ACT_OBSERVE;

  `OVSE_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid)
  `OVSE_ASSERT_IMP(a_busy_on_result, clk, rst_n, out_valid, busy)
  `OVSE_ASSERT_NXT(a_free_after_result, clk, rst_n, out_valid, !busy)
  `OVSE_ASSERT_NXT(a_load_quick, clk, rst_n, load_acc, !busy)
  `OVSE_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
endmodule

bind online_viterbi_state_estimator ovse_checker u_ovse_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .in_word, .cfg_ready);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the online viterbi state estimator: loads the hmm
// tables, runs observe sequences under several state and symbol counts, and
// compares each best-state word against an in-bench score predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ovse_pkg::*;

  // actions the block must ignore
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam longint SCORE_HI = (64'sd1 <<< (DEF_SCORE_WIDTH - 1)) - 1;
  localparam longint SCORE_LO = -SCORE_HI - 1;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [4:0] cfg_data;

  online_viterbi_state_estimator uut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---- predictor state: tables, double-buffered scores, counts ----
  logic signed [15:0] pi_tab [DEF_MAX_STATES];
  logic signed [15:0] trans_tab [DEF_MAX_STATES * DEF_MAX_STATES];
  logic signed [15:0] emis_tab [DEF_MAX_STATES * DEF_MAX_SYMBOLS];
  logic signed [23:0] path_sc [DEF_MAX_STATES];
  logic               seq_open;
  logic [4:0]         states_reg;
  logic [4:0]         symbols_reg;

  out_word_t expected_q[$];
  int mismatches;
  int words_sent;
  int results_seen;
  int sat_hits;

  bit allow_gaps;

  function automatic logic signed [23:0] sat_score(input longint v);
    if (v < SCORE_LO) return SCORE_LO[23:0];
    if (v > SCORE_HI) return SCORE_HI[23:0];
    return v[23:0];
  endfunction

  function automatic int clamp_count(input logic [4:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // predictor for one word; a viterbi step and an expected word per in-use observe
  task automatic predict_word(input in_word_t w);
    logic signed [23:0] nxt [DEF_MAX_STATES];
    longint acc;
    longint cand;
    int n;
    int best;
    case (w.action)
      ACT_LOAD_PI: pi_tab[w.to_index] = w.log_value;
      ACT_LOAD_TR: trans_tab[w.from_state * DEF_MAX_STATES + w.to_index] = w.log_value;
      ACT_LOAD_EM: emis_tab[w.from_state * DEF_MAX_SYMBOLS + w.to_index] = w.log_value;
      ACT_RESTART: begin
        foreach (path_sc[j]) path_sc[j] = '0;
        seq_open = 1'b0;
      end
      ACT_OBSERVE: begin
        if (w.symbol < clamp_count(symbols_reg, DEF_MAX_SYMBOLS)) begin
          n = clamp_count(states_reg, DEF_MAX_STATES);
          for (int j = 0; j < n; j++) begin
            if (!seq_open) begin
              acc = pi_tab[j];
            end else begin
              acc = sat_score(longint'(path_sc[0]) + trans_tab[j]);
              for (int k = 1; k < n; k++) begin
                cand = sat_score(longint'(path_sc[k]) + trans_tab[k * DEF_MAX_STATES + j]);
                if (cand > acc) acc = cand;
              end
            end
            nxt[j] = sat_score(acc + emis_tab[j * DEF_MAX_SYMBOLS + w.symbol]);
            if (nxt[j] == SCORE_LO[23:0] || nxt[j] == SCORE_HI[23:0]) sat_hits++;
          end
          for (int j = 0; j < n; j++) path_sc[j] = nxt[j];
          seq_open = 1'b1;
          best = 0;
          for (int k = 1; k < n; k++)
            if (path_sc[k] > path_sc[best]) best = k;
          expected_q.insert(expected_q.size(),
                            '{best_state: best[3:0], echo_symbol: w.symbol});
        end
      end
      default: ;
    endcase
  endtask

  // ---- result checker: every strobed word against the oldest expectation ----
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: best_state %0d echo_symbol %0d",
                   out_word.best_state, out_word.echo_symbol);
      end else begin
        out_word_t exp_w;
        exp_w = expected_q.pop_front();
        if (out_word.best_state !== exp_w.best_state ||
            out_word.echo_symbol !== exp_w.echo_symbol) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: best_state exp %0d got %0d, echo_symbol exp %0d got %0d",
                     exp_w.best_state, out_word.best_state,
                     exp_w.echo_symbol, out_word.echo_symbol);
        end
      end
    end
  end

  // ---- sender side ----
  // start stays high after acceptance so back-to-back words need one update only
  task automatic send_word(input in_word_t w);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    words_sent++;
    predict_word(w);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // random gap between words, bursty; none in the closing stretch
  task automatic maybe_gap();
    if (allow_gaps && $urandom_range(0, 3) == 0)
      pause_sender($urandom_range(1, 12));
  endtask

  // wait for all expected words, then for the block to go quiet
  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_STATES) states_reg = val;
    else                   symbols_reg = val;
  endtask

  function automatic in_word_t make_word(input logic [2:0] act, input logic [3:0] row,
                                         input logic [3:0] col, input logic [15:0] val,
                                         input logic [3:0] sym);
    in_word_t w;
    w.action = act; w.from_state = row; w.to_index = col;
    w.log_value = val; w.symbol = sym;
    return w;
  endfunction

  // log value: mostly negative probabilities, with the extremes and a few
  // positive values so both saturation limits stay reachable
  function automatic logic [15:0] rand_log();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h0000;
      2:       return 16'($urandom_range(0, 16'h7FFF));
      default: return 16'(-$urandom_range(0, 4096));
    endcase
  endfunction

  // fill the table entries of the first ns states; mode 0 random, 1 coarse
  // values for ties, 2 all minimum, 3 all maximum
  task automatic load_all(input int mode, input int ns);
    logic [15:0] v;
    for (int a = 1; a <= 3; a++)
      for (int r = 0; r < ns; r++)
        for (int c = 0; c < DEF_MAX_SYMBOLS; c++) begin
          if (a == 1 && r != 0) continue;
          if (a != 3 && c >= ns) continue;
          case (mode)
            0: v = rand_log();
            1: v = $urandom_range(0, 1) ? 16'hFF00 : 16'h0000;
            2: v = 16'h8000;
            default: v = 16'h7FFF;
          endcase
          send_word(make_word(a[2:0], r[3:0], c[3:0], v, 4'($urandom)));
          maybe_gap();
        end
  endtask

  // ---- test tasks ----
  task automatic test_directed();
    // smallest model: one state, one symbol
    write_reg(CFG_STATES, 5'd1);
    write_reg(CFG_SYMBOLS, 5'd1);
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd0));
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd1));   // symbol not in use
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd15));  // symbol not in use
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd0));
    // unknown actions do nothing
    send_word(make_word(ACT_SPARE_5, 4'd15, 4'd15, 16'hFFFF, 4'd0));
    send_word(make_word(ACT_SPARE_6, 4'd0, 4'd0, 16'h8000, 4'd15));
    send_word(make_word(ACT_SPARE_7, 4'd5, 4'd10, 16'h7FFF, 4'd3));
    // zero counts act as one
    write_reg(CFG_STATES, 5'd0);
    write_reg(CFG_SYMBOLS, 5'd0);
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd0));
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd2));
    // counts above the maximum act as the maximum
    write_reg(CFG_STATES, 5'd31);
    write_reg(CFG_SYMBOLS, 5'd31);
    send_word(make_word(ACT_RESTART, 4'd0, 4'd0, 16'h0, 4'd0));
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd15));
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd0));
    // a table update mid sequence, then restart back to the first-symbol path
    send_word(make_word(ACT_LOAD_EM, 4'd15, 4'd15, 16'h0000, 4'd0));
    send_word(make_word(ACT_LOAD_TR, 4'd15, 4'd0, 16'h8000, 4'd0));
    send_word(make_word(ACT_LOAD_PI, 4'd0, 4'd15, 16'h0000, 4'd0));
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd15));
    send_word(make_word(ACT_RESTART, 4'd0, 4'd0, 16'h0, 4'd0));
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd7));
    // fewer states: upper scores stay frozen, then come back into play
    write_reg(CFG_STATES, 5'd3);
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd9));
    write_reg(CFG_STATES, 5'd16);
    write_reg(CFG_SYMBOLS, 5'd16);
    send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0, 4'd4));
    pause_sender(0);
  endtask

  // long runs on constant tables drive scores into both saturation limits
  task automatic test_saturation();
    write_reg(CFG_STATES, 5'd2);
    load_all(2, 2);
    send_word(make_word(ACT_RESTART, 4'd0, 4'd0, 16'h0, 4'd0));
    repeat (140) begin send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0,
                                           4'($urandom_range(0, 15)))); maybe_gap(); end
    load_all(3, 2);
    send_word(make_word(ACT_RESTART, 4'd0, 4'd0, 16'h0, 4'd0));
    repeat (140) begin send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0,
                                           4'($urandom_range(0, 15)))); maybe_gap(); end
  endtask

  // coarse table values make equal scores common, exercising lowest-index ties
  task automatic test_ties();
    write_reg(CFG_STATES, 5'd6);
    load_all(1, 6);
    send_word(make_word(ACT_RESTART, 4'd0, 4'd0, 16'h0, 4'd0));
    repeat (60) begin send_word(make_word(ACT_OBSERVE, 4'd0, 4'd0, 16'h0,
                                          4'($urandom_range(0, 15)))); maybe_gap(); end
  endtask

  // random sequences: mostly observes with symbols in use, some restarts and
  // table rewrites, a little noise
  task automatic run_random(input int count);
    int sym_n;
    int pick;
    sym_n = clamp_count(symbols_reg, DEF_MAX_SYMBOLS);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 72)
        send_word(make_word(ACT_OBSERVE, 4'($urandom), 4'($urandom), 16'($urandom),
                            4'($urandom_range(0, sym_n - 1))));
      else if (pick < 76)
        send_word(make_word(ACT_RESTART, 4'($urandom), 4'($urandom), 16'($urandom),
                            4'($urandom)));
      else if (pick < 92)
        send_word(make_word(3'($urandom_range(ACT_LOAD_PI, ACT_LOAD_EM)), 4'($urandom),
                            4'($urandom), rand_log(), 4'($urandom)));
      else if (pick < 96)
        send_word(make_word(ACT_OBSERVE, 4'($urandom), 4'($urandom), 16'($urandom),
                            4'($urandom)));
      else
        send_word(make_word(3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7)), 4'($urandom),
                            4'($urandom), 16'($urandom), 4'($urandom)));
      maybe_gap();
    end
  endtask

  task automatic test_random();
    // small state counts keep most observe words short
    write_reg(CFG_STATES, 5'd16); write_reg(CFG_SYMBOLS, 5'd16); run_random(100);
    write_reg(CFG_STATES, 5'd1);  write_reg(CFG_SYMBOLS, 5'd1);  run_random(60);
    write_reg(CFG_STATES, 5'd4);  write_reg(CFG_SYMBOLS, 5'd9);  run_random(150);
    write_reg(CFG_STATES, 5'd0);  write_reg(CFG_SYMBOLS, 5'd31); run_random(50);
    write_reg(CFG_STATES, 5'd2);  write_reg(CFG_SYMBOLS, 5'd16); run_random(150);
    write_reg(CFG_STATES, 5'd29); write_reg(CFG_SYMBOLS, 5'd0);  run_random(50);
    write_reg(CFG_STATES, 5'($urandom_range(2, 8)));
    write_reg(CFG_SYMBOLS, 5'($urandom_range(1, 16)));
    run_random(130);
    // closing stretch back to back, no gaps
    allow_gaps = 1'b0;
    write_reg(CFG_STATES, 5'd5); write_reg(CFG_SYMBOLS, 5'd16); run_random(100);
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_STATES;
    cfg_data    = '0;
    mismatches  = 0;
    words_sent  = 0;
    results_seen = 0;
    sat_hits    = 0;
    allow_gaps  = 1'b1;
    foreach (path_sc[j]) path_sc[j] = '0;
    seq_open    = 1'b0;
    states_reg  = 5'd16;
    symbols_reg = 5'd16;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every table entry written before the first observe
    load_all(0, DEF_MAX_STATES);
    test_directed();
    test_saturation();
    test_ties();
    test_random();

    drain();
    repeat (400) @(posedge clk);
    $display("sent %0d words, checked %0d results, %0d saturated scores seen",
             words_sent, results_seen, sat_hits);
    $display("covered table loads, restarts, ignored words, ties and count extremes");
    if (mismatches == 0 && expected_q.size() == 0)
      $display("online_viterbi_state_estimator: match");
    else
      $display("online_viterbi_state_estimator: mismatch");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("online_viterbi_state_estimator: mismatch");
    $finish;
  end

endmodule

### online_viterbi_state_estimator.f
+incdir+sv
sv/ovse_pkg.sv
sv/ovse_ram.sv
sv/online_viterbi_state_estimator.sv
sv/ovse_checker.sv
tb/tb.sv
